@@ rtl/ict_pkg.sv @@
// shared types, constants and helper functions for the instruction cache tag model
// no dependencies; used by multi_cpu_icache_tag_model
`timescale 1ns / 1ps
`default_nettype none

package ict_pkg;

    // default geometry
    localparam int NUM_CPU_DEF    = 4;
    localparam int LINE_BITS_DEF  = 5;
    localparam int LINES_DEF      = 256;
    localparam int ASSOC_BITS_DEF = 2;
    localparam int ADDR_BITS_DEF  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MISS_PENALTY_NS = 2'd0;
    localparam cfg_idx_t CFG_MISS_BUDGET     = 2'd1;
    localparam cfg_idx_t CFG_FULL_MODE       = 2'd2;

    localparam logic [15:0] MISS_PENALTY_RST = 16'd50;
    localparam logic [15:0] MISS_BUDGET_RST  = 16'd8;
    localparam logic [15:0] LFSR_SEED        = 16'hACE1;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // fibonacci lfsr, taps 16 14 13 11, shifting right
    function automatic logic [15:0] lfsr_advance(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/multi_cpu_icache_tag_model.sv @@
// per-cpu set-associative instruction cache tag model with random replacement
// depends on ict_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each accepted fetch looks up the tag store of its cpu and returns one result item with the
// hit flag, the way used, the per-cpu access and miss counts, the miss time charged and a
// memory read flag. The tags and valid bits of a set sit together in one row of a single-port
// synchronous memory: the set's row is read first, then all ways are compared in parallel,
// the per-cpu counters are updated and, on a miss, the row is written back. No new fetch is
// taken while an item is in flight, and an item waits while the result register is stalled.
// After reset a clearing pass writes every row invalid, one row per cycle, all
// NUM_CPU * LINES / 2^ASSOC_BITS rows (256 at the default geometry), and no fetch is taken
// until it ends; configuration writes are taken at any time and must come while no item is in
// flight. A cpu_index at or above NUM_CPU gives an all-zero result and leaves the state alone.

module multi_cpu_icache_tag_model #(
    parameter int NUM_CPU    = ict_pkg::NUM_CPU_DEF,
    parameter int LINE_BITS  = ict_pkg::LINE_BITS_DEF,
    parameter int LINES      = ict_pkg::LINES_DEF,
    parameter int ASSOC_BITS = ict_pkg::ASSOC_BITS_DEF,
    parameter int ADDR_BITS  = ict_pkg::ADDR_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         cpu_index,
    input  wire logic [31:0]                        fetch_address,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    hit,
    output logic [1:0]                              way_used,
    output logic [31:0]                             access_total,
    output logic [31:0]                             miss_total,
    output logic [31:0]                             stall_ns,
    output logic [31:0]                             cumulative_miss_ns,
    output logic                                    mem_read_request,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire ict_pkg::cfg_idx_t                  cfg_index,
    input  wire logic [ict_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int EFF_ADDR = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TAG_W    = EFF_ADDR - LINE_BITS;
    localparam int ENT_W    = TAG_W + 1;
    localparam int WAYS     = 1 << ASSOC_BITS;
    localparam int WAY_W    = (ASSOC_BITS > 0) ? ASSOC_BITS : 1;
    localparam int SETS     = (LINES >= WAYS) ? LINES / WAYS : 1;
    localparam int ROWS     = NUM_CPU * SETS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CPU_W    = (NUM_CPU > 1) ? $clog2(NUM_CPU) : 1;
    localparam int ROW_BITS = WAYS * ENT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ROW_W-1:0]    clr_reg, clr_next;

    logic [15:0]         pen_reg;
    logic [15:0]         bud_reg;
    logic                full_reg;

    logic [CPU_W-1:0]    cpu_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                cpu_ok_reg;

    logic [31:0]         acc_reg  [NUM_CPU];
    logic [31:0]         miss_reg [NUM_CPU];
    logic [31:0]         pend_reg [NUM_CPU];
    logic [31:0]         tot_reg  [NUM_CPU];
    logic [15:0]         lfsr_reg, lfsr_next;

    logic [ROW_BITS-1:0] tag_mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;

    logic                out_valid_reg, out_valid_next;
    logic                hit_reg;
    logic [1:0]          way_reg;
    logic [31:0]         acc_out_reg;
    logic [31:0]         miss_out_reg;
    logic [31:0]         stall_out_reg;
    logic [31:0]         cum_out_reg;
    logic                req_out_reg;

    // input decode
    logic                in_accept;
    logic [TAG_W-1:0]    tag_in;
    logic [31:0]         set32;
    logic [CPU_W+1:0]    cpu_ext;
    logic [CPU_W-1:0]    cpu_in;
    logic [31:0]         row32;
    logic [ROW_W-1:0]    row_in;
    logic                cpu_ok_in;

    assign in_accept = in_valid && !in_stall;
    assign tag_in    = fetch_address[EFF_ADDR-1:LINE_BITS];
    assign set32     = (32'(tag_in) & 32'(LINES - 1)) >> ASSOC_BITS;
    assign cpu_ext   = {{CPU_W{1'b0}}, cpu_index};
    assign cpu_in    = cpu_ext[CPU_W-1:0];
    assign row32     = 32'(cpu_in) * 32'(SETS) + set32;
    assign row_in    = row32[ROW_W-1:0];
    assign cpu_ok_in = {30'b0, cpu_index} < 32'(NUM_CPU);

    // lookup and update
    logic                out_free;
    logic                do_item;
    logic                commit;
    logic                hit_any;
    logic [WAY_W-1:0]    hit_way;
    logic                inv_any;
    logic [WAY_W-1:0]    inv_way;
    logic [15:0]         lfsr_step;
    logic [WAY_W-1:0]    fill_way;
    logic [WAY_W-1:0]    way_sel;
    logic [WAY_W+1:0]    way_ext;
    logic [ROW_BITS-1:0] new_row;
    logic [31:0]         acc_cur, miss_cur, pend_cur, tot_cur;
    logic [31:0]         acc_next, miss_next, pend_next, tot_next;
    logic [31:0]         pend_add, tot_add, limit;
    logic                timed;
    logic                stall_due;
    logic [31:0]         stall_val;

    assign out_free = !out_valid_reg || !out_stall;
    assign do_item  = (state_reg == S_LOOK) && out_free;
    assign commit   = do_item && cpu_ok_reg;

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_any && rdata_reg[w*ENT_W + TAG_W]
                && (rdata_reg[w*ENT_W +: TAG_W] == tag_reg))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!inv_any && !rdata_reg[w*ENT_W + TAG_W])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    assign lfsr_step = ict_pkg::lfsr_advance(lfsr_reg);
    assign fill_way  = inv_any ? inv_way : (lfsr_step[WAY_W-1:0] & WAY_W'(WAYS - 1));
    assign way_sel   = hit_any ? hit_way : fill_way;
    assign way_ext   = {2'b00, way_sel};
    assign lfsr_next = (!hit_any && !inv_any) ? lfsr_step : lfsr_reg;

    always_comb
    begin
        new_row = rdata_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == fill_way)
            begin
                new_row[w*ENT_W +: ENT_W] = {1'b1, tag_reg};
            end
        end
    end

    assign acc_cur  = acc_reg[cpu_reg];
    assign miss_cur = miss_reg[cpu_reg];
    assign pend_cur = pend_reg[cpu_reg];
    assign tot_cur  = tot_reg[cpu_reg];

    assign timed     = !hit_any && !full_reg;
    assign limit     = 32'(pen_reg) * 32'(bud_reg);
    assign pend_add  = ict_pkg::sat_add32(pend_cur, {16'b0, pen_reg});
    assign tot_add   = ict_pkg::sat_add32(tot_cur, {16'b0, pen_reg});
    assign stall_due = timed && (pend_add > limit);

    assign acc_next  = ict_pkg::sat_add32(acc_cur, 32'd1);
    assign miss_next = hit_any ? miss_cur : ict_pkg::sat_add32(miss_cur, 32'd1);
    assign pend_next = !timed ? pend_cur : (stall_due ? 32'd0 : pend_add);
    assign tot_next  = timed ? tot_add : tot_cur;
    assign stall_val = stall_due ? pend_add : 32'd0;

    // memory port control
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = commit && !hit_any;
            mem_waddr = row_reg;
            mem_wdata = new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rdata_reg <= tag_mem[row_in];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = do_item ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            pen_reg       <= ict_pkg::MISS_PENALTY_RST;
            bud_reg       <= ict_pkg::MISS_BUDGET_RST;
            full_reg      <= 1'b0;
            lfsr_reg      <= ict_pkg::LFSR_SEED;
            for (int i = 0; i < NUM_CPU; i++)
            begin
                acc_reg[i]  <= '0;
                miss_reg[i] <= '0;
                pend_reg[i] <= '0;
                tot_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ict_pkg::CFG_MISS_PENALTY_NS: pen_reg  <= cfg_data;
                    ict_pkg::CFG_MISS_BUDGET:     bud_reg  <= cfg_data;
                    ict_pkg::CFG_FULL_MODE:       full_reg <= cfg_data[0];
                    default:                      ;
                endcase
            end
            if (commit)
            begin
                lfsr_reg          <= lfsr_next;
                acc_reg[cpu_reg]  <= acc_next;
                miss_reg[cpu_reg] <= miss_next;
                pend_reg[cpu_reg] <= pend_next;
                tot_reg[cpu_reg]  <= tot_next;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cpu_reg    <= cpu_in;
            tag_reg    <= tag_in;
            row_reg    <= row_in;
            cpu_ok_reg <= cpu_ok_in;
        end
        if (do_item)
        begin
            if (cpu_ok_reg)
            begin
                hit_reg       <= hit_any;
                way_reg       <= way_ext[1:0];
                acc_out_reg   <= acc_next;
                miss_out_reg  <= miss_next;
                stall_out_reg <= stall_val;
                cum_out_reg   <= tot_next;
                req_out_reg   <= !hit_any && full_reg;
            end
            else
            begin
                hit_reg       <= 1'b0;
                way_reg       <= 2'd0;
                acc_out_reg   <= 32'd0;
                miss_out_reg  <= 32'd0;
                stall_out_reg <= 32'd0;
                cum_out_reg   <= 32'd0;
                req_out_reg   <= 1'b0;
            end
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign cfg_ready          = 1'b1;
    assign out_valid          = out_valid_reg;
    assign hit                = hit_reg;
    assign way_used           = way_reg;
    assign access_total       = acc_out_reg;
    assign miss_total         = miss_out_reg;
    assign stall_ns           = stall_out_reg;
    assign cumulative_miss_ns = cum_out_reg;
    assign mem_read_request   = req_out_reg;

endmodule

`default_nettype wire

@@ rtl/ict_checker.sv @@
// port-level checks for multi_cpu_icache_tag_model and the bind that attaches them
// depends on multi_cpu_icache_tag_model port names
`timescale 1ns / 1ps
`default_nettype none

module ict_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        hit,
    input wire logic [31:0] access_total,
    input wire logic [31:0] miss_total,
    input wire logic [31:0] stall_ns,
    input wire logic        mem_read_request
);

    // a stalled result item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(access_total) && $stable(hit))
        else $error("result item changed while stalled");

    // misses never outnumber accesses
    a_miss_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> miss_total <= access_total)
        else $error("miss count above access count");

    // read request only on a miss
    a_req_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_read_request |-> !hit && stall_ns == 32'd0)
        else $error("memory read request on a hit or with a stall");

    // stall time only released on a miss
    a_stall_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stall_ns != 32'd0 |-> !hit && miss_total != 32'd0)
        else $error("stall released without a miss");

endmodule

bind multi_cpu_icache_tag_model ict_port_checks u_ict_port_checks (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .access_total     (access_total),
    .miss_total       (miss_total),
    .stall_ns         (stall_ns),
    .mem_read_request (mem_read_request)
);

`default_nettype wire
